/* hdl/scba_pkg.sv */
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size-class bitmap allocator
// Holds the status codes, the opcode codes, the arena geometry and the queue
// entry that the front end hands to the back end.
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_LARGE = 3'd2;
  localparam logic [2:0] ST_OOM   = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;

  localparam int MIN_SHIFT = 4;
  localparam int MAX_SHIFT = 20;
  localparam int WORD_BITS = 64;

  // Arena geometry; the handle fields on the ports are sized for it.
  localparam int SLOTS_PER_ARENA  = 512;
  localparam int ARENAS_PER_CLASS = 4;

  // One classified request as it waits between front and back end.
  typedef struct packed {
    logic       op;
    logic [4:0] cls;
    logic [1:0] arena;
    logic [8:0] slot;
    logic [2:0] status;
  } scba_req_t;

  // Result of one request.
  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  cls;
    logic [1:0]  arena;
    logic [8:0]  slot;
    logic [20:0] bsize;
  } scba_res_t;

endpackage

/* hdl/scba_front.sv */
// ----------------------------------------------------------------------------
// scba_front: request intake and classification
// Rounds the size to its class, settles the early error codes and keeps the
// classified requests in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module scba_front #(
  parameter int NUM_CLASSES = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic                opcode,
  input  logic [23:0]         request_size,
  input  logic [1:0]          free_arena,
  input  logic [8:0]          free_slot,
  input  logic                busy_clear,
  output logic                head_v,
  output scba_pkg::scba_req_t head,
  input  logic                head_pop
);
  import scba_pkg::*;

  scba_req_t  q_r [2];
  scba_req_t  q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  scba_req_t  req;
  logic [19:0] sm1;
  logic [4:0]  k;
  logic        oversize;
  logic        acc;

  // Class: smallest k >= 4 with 2^k >= size, from the top bit of size - 1.
  always_comb begin
    sm1 = 20'(request_size - 24'd1);
    k   = 5'(MIN_SHIFT);
    for (int i = 0; i < 20; i++) begin
      if (sm1[i] && (i + 1) > MIN_SHIFT) k = 5'(i + 1);
    end
    oversize = (request_size > 24'(1 << MAX_SHIFT)) ||
               (32'(k - 5'(MIN_SHIFT)) >= NUM_CLASSES);
    req.op     = opcode;
    req.arena  = free_arena;
    req.slot   = free_slot;
    req.cls    = 5'(k - 5'(MIN_SHIFT));
    if (request_size == 24'd0) begin
      req.status = ST_ZERO;
    end else if (oversize) begin
      req.status = ST_LARGE;
    end else if (opcode == OP_FREE && (free_slot == 9'd0 ||
               32'(free_slot) >= SLOTS_PER_ARENA ||
               32'(free_arena) >= ARENAS_PER_CLASS)) begin
      req.status = ST_BAD;
    end else begin
      req.status = ST_OK;
    end
  end

  assign full   = (cnt_r == 2'd2) || busy_clear;
  assign acc    = push && !full;
  assign head_v = (cnt_r != 2'd0);
  assign head   = q_r[0];

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (head_pop && head_v) begin
      q_nxt[0] = q_r[1];
      cnt_nxt  = cnt_nxt - 2'd1;
    end
    if (acc) begin
      q_nxt[cnt_nxt[0]] = req;
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hdl/scba_back.sv */
// ----------------------------------------------------------------------------
// scba_back: bitmap engine
// Owns the slot bitmap memory, clears it after reset, and carries out the
// first-fit search for allocations and the bit clears for frees.
// ----------------------------------------------------------------------------
module scba_back #(
  parameter int NUM_CLASSES = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  output logic                busy_clear,
  input  logic                head_v,
  input  scba_pkg::scba_req_t head,
  output logic                head_pop,
  output logic                res_v,
  output scba_pkg::scba_res_t res,
  input  logic                res_pop
);
  import scba_pkg::*;

  localparam int WPA    = (SLOTS_PER_ARENA + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH  = NUM_CLASSES * ARENAS_PER_CLASS * WPA;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WI_W   = (WPA > 1) ? $clog2(WPA) : 1;
  localparam int AR_W   = (ARENAS_PER_CLASS > 1) ? $clog2(ARENAS_PER_CLASS) : 1;
  localparam int SL_W   = $clog2(WPA * WORD_BITS);
  localparam int LAST_BITS = SLOTS_PER_ARENA - (WPA - 1) * WORD_BITS;
  localparam logic [63:0] HI_MASK =
    (LAST_BITS == WORD_BITS) ? 64'd0 : ~((64'd1 << LAST_BITS) - 64'd1);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACHK  = 3'd2;
  localparam logic [2:0] S_ASETF = 3'd3;
  localparam logic [2:0] S_FCHK  = 3'd4;
  localparam logic [2:0] S_FZ    = 3'd5;

  logic [63:0]       mem [DEPTH];
  logic [63:0]       rdata_r;
  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [AR_W-1:0]   a_r, a_nxt;
  logic [WI_W-1:0]   w_r, w_nxt;
  logic [4:0]        cls_r, cls_nxt;
  logic [5:0]        bit_r, bit_nxt;
  logic [63:0]       w0_r, w0_nxt;
  logic              res_v_r, res_v_nxt;
  scba_res_t         res_r, res_nxt;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [63:0]       wdata;
  logic [63:0]       occ;
  logic              found;
  logic [5:0]        fz;
  logic [SL_W-1:0]   s_idx;
  logic              take;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [4:0] c,
                                                 input logic [AR_W-1:0] a,
                                                 input logic [WI_W-1:0] w);
    return ADDR_W'((32'(c) * ARENAS_PER_CLASS + 32'(a)) * WPA + 32'(w));
  endfunction

  // Bitmap store, read-first with a bypass so a read of the word being
  // written returns the new data.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= (we && waddr == addr_nxt) ? wdata : mem[addr_nxt];
  end

  assign busy_clear = (state_r == S_CLR);
  assign res_v      = res_v_r;
  assign res        = res_r;
  assign take       = (state_r == S_IDLE) && head_v && (!res_v_r || res_pop);
  assign head_pop   = take;

  // First clear slot in the word under test; slot 0 and slots past the arena
  // end count as taken.
  always_comb begin
    occ = rdata_r;
    if (w_r == WI_W'(0)) occ[0] = 1'b1;
    if (32'(w_r) == WPA - 1) occ = occ | HI_MASK;
    found = ~&occ;
    fz    = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (!occ[i]) fz = 6'(i);
    end
    s_idx = SL_W'(32'(w_r) * WORD_BITS + 32'(fz));
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    addr_nxt  = addr_r;
    a_nxt     = a_r;
    w_nxt     = w_r;
    cls_nxt   = cls_r;
    bit_nxt   = bit_r;
    w0_nxt    = w0_r;
    res_nxt   = res_r;
    res_v_nxt = res_v_r && !res_pop;
    we        = 1'b0;
    waddr     = addr_r;
    wdata     = rdata_r;
    unique case (state_r)
      S_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = 64'd0;
        clr_nxt = clr_r + ADDR_W'(1);
        if (32'(clr_r) == DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          cls_nxt = head.cls;
          res_nxt = '0;
          if (head.status != ST_OK) begin
            res_nxt.status = head.status;
            res_v_nxt      = 1'b1;
          end else if (head.op == OP_ALLOC) begin
            a_nxt     = AR_W'(0);
            w_nxt     = WI_W'(0);
            addr_nxt  = addr_of(head.cls, AR_W'(0), WI_W'(0));
            state_nxt = S_ACHK;
          end else begin
            a_nxt     = AR_W'(head.arena);
            w_nxt     = WI_W'(head.slot >> 6);
            bit_nxt   = head.slot[5:0];
            addr_nxt  = addr_of(head.cls, AR_W'(head.arena), WI_W'(head.slot >> 6));
            state_nxt = S_FCHK;
          end
        end
      end
      S_ACHK: begin
        if (w_r == WI_W'(0)) w0_nxt = rdata_r;
        if (found && !(w_r == WI_W'(0) && rdata_r[0])) begin
          we    = 1'b1;
          wdata = rdata_r | (64'd1 << fz);
          res_nxt.status = ST_OK;
          res_nxt.cls    = cls_r;
          res_nxt.arena  = 2'(a_r);
          res_nxt.slot   = 9'(s_idx);
          res_nxt.bsize  = 21'(1) << (cls_r + 5'(MIN_SHIFT));
          res_v_nxt      = 1'b1;
          state_nxt      = S_IDLE;
          if (32'(s_idx) == SLOTS_PER_ARENA - 1) begin
            if (w_r == WI_W'(0)) begin
              wdata[0] = 1'b1;
            end else begin
              state_nxt = S_ASETF;
            end
          end
        end else if (!(w_r == WI_W'(0) && rdata_r[0]) && 32'(w_r) < WPA - 1) begin
          w_nxt    = w_r + WI_W'(1);
          addr_nxt = addr_of(cls_r, a_r, w_r + WI_W'(1));
        end else if (32'(a_r) < ARENAS_PER_CLASS - 1) begin
          a_nxt    = a_r + AR_W'(1);
          w_nxt    = WI_W'(0);
          addr_nxt = addr_of(cls_r, a_r + AR_W'(1), WI_W'(0));
        end else begin
          res_nxt   = '0;
          res_nxt.status = ST_OOM;
          res_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ASETF: begin
        we        = 1'b1;
        waddr     = addr_of(cls_r, a_r, WI_W'(0));
        wdata     = w0_r | 64'd1;
        state_nxt = S_IDLE;
      end
      S_FCHK: begin
        we    = 1'b1;
        wdata = rdata_r & ~(64'd1 << bit_r);
        res_nxt.status = ST_OK;
        res_nxt.cls    = cls_r;
        res_nxt.arena  = 2'(a_r);
        res_nxt.slot   = 9'(32'(w_r) * WORD_BITS + 32'(bit_r));
        res_nxt.bsize  = 21'(1) << (cls_r + 5'(MIN_SHIFT));
        if (w_r == WI_W'(0)) begin
          wdata[0]  = 1'b0;
          res_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt  = addr_of(cls_r, a_r, WI_W'(0));
          state_nxt = S_FZ;
        end
      end
      S_FZ: begin
        we        = 1'b1;
        wdata     = rdata_r & ~64'd1;
        res_v_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    a_r    <= a_nxt;
    w_r    <= w_nxt;
    cls_r  <= cls_nxt;
    bit_r  <= bit_nxt;
    w0_r   <= w0_nxt;
    res_r  <= res_nxt;
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      res_v_r <= res_v_nxt;
    end
  end

endmodule

/* hdl/size_class_bitmap_allocator_top.sv */
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator_top: size-class bitmap slab allocator
// Allocates and frees fixed-size slots in per-class bitmap arenas.
// ----------------------------------------------------------------------------
// An error request skips the bitmap; a free clears the slot bit and the arena
// full flag (a second write outside word 0); an allocate reads bitmap words in
// turn (at most 32, one per full arena) and flags an arena full when it fills.
// Throughput: one request at a time in the engine; a two-entry queue in front
// keeps taking requests while the engine or the result waits. Reset: the bitmap
// is cleared one word per cycle, 544 words by default, with full held high.
module size_class_bitmap_allocator_top #(
  parameter int NUM_CLASSES = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_opcode,
  input  logic [23:0] in_request_size,
  input  logic [1:0]  in_free_arena,
  input  logic [8:0]  in_free_slot,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [4:0]  out_class_index,
  output logic [1:0]  out_arena_index,
  output logic [8:0]  out_slot_index,
  output logic [20:0] out_block_size
);
  import scba_pkg::*;

  scba_req_t head;
  scba_res_t res;
  logic      head_v;
  logic      head_pop;
  logic      busy_clear;
  logic      res_v;

  // The front end classifies each request and queues it.
  scba_front #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .opcode       (in_opcode),
    .request_size (in_request_size),
    .free_arena   (in_free_arena),
    .free_slot    (in_free_slot),
    .busy_clear   (busy_clear),
    .head_v       (head_v),
    .head         (head),
    .head_pop     (head_pop)
  );

  // The back end walks the bitmap and holds the finished result.
  scba_back #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy_clear (busy_clear),
    .head_v     (head_v),
    .head       (head),
    .head_pop   (head_pop),
    .res_v      (res_v),
    .res        (res),
    .res_pop    (pop)
  );

  assign empty           = !res_v;
  assign out_status      = res.status;
  assign out_class_index = res.cls;
  assign out_arena_index = res.arena;
  assign out_slot_index  = res.slot;
  assign out_block_size  = res.bsize;

endmodule

/* sim/tb_size_class_bitmap_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_bitmap_allocator_top: self-checking bench for the allocator
// Drives allocate and free requests through the push/full queue and checks
// every result popped against a behavioral bitmap predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_size_class_bitmap_allocator_top;
  import scba_pkg::*;

  localparam int NCLS    = 17;
  localparam int NSLOT   = 512;
  localparam int NARENA  = 4;
  localparam int WDOG_MAX = 20000;

  // One input request as the driver presents it.
  typedef struct packed {
    logic        op;
    logic [23:0] size;
    logic [1:0]  arena;
    logic [8:0]  slot;
  } alloc_req_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        in_opcode;
  logic [23:0] in_request_size;
  logic [1:0]  in_free_arena;
  logic [8:0]  in_free_slot;
  logic        empty;
  logic        pop;
  logic [2:0]  out_status;
  logic [4:0]  out_class_index;
  logic [1:0]  out_arena_index;
  logic [8:0]  out_slot_index;
  logic [20:0] out_block_size;

  size_class_bitmap_allocator_top u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_opcode(in_opcode), .in_request_size(in_request_size),
    .in_free_arena(in_free_arena), .in_free_slot(in_free_slot),
    .empty(empty), .pop(pop), .out_status(out_status),
    .out_class_index(out_class_index), .out_arena_index(out_arena_index),
    .out_slot_index(out_slot_index), .out_block_size(out_block_size)
  );

  // Predictor state: one bit per slot, slot 0 acting as the arena full flag.
  logic [NSLOT-1:0] slot_map [NCLS][NARENA];

  alloc_req_t pending_reqs[$];
  scba_res_t  expected_results[$];
  // Requests of blocks believed allocated; their sizes set the class of frees.
  alloc_req_t live_blocks[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off_cycles;
  int  mismatch_count;
  int  wdog;
  bit  stim_done;

  // Class index for a nonzero size, or -1 when the size exceeds the top class.
  function automatic int size_to_class(input logic [23:0] sz);
    int k;
    if (sz > (24'd1 << MAX_SHIFT)) return -1;
    for (k = MIN_SHIFT; k <= MAX_SHIFT; k++)
      if ((32'd1 << k) >= sz) break;
    if (k - MIN_SHIFT >= NCLS) return -1;
    return k - MIN_SHIFT;
  endfunction

  // Applies one request to the predictor bitmap and returns its result.
  function automatic scba_res_t predict_allocation(input alloc_req_t r);
    scba_res_t res;
    int c;
    bit found;
    res = '0;
    res.status = ST_OK;
    found = 0;
    c = size_to_class(r.size);
    if (r.size == 0) begin
      res.status = ST_ZERO;
    end else if (c < 0) begin
      res.status = ST_LARGE;
    end else if (r.op == OP_ALLOC) begin
      for (int a = 0; a < NARENA && !found; a++) begin
        if (slot_map[c][a][0]) continue;
        for (int s = 1; s < NSLOT; s++) begin
          if (!slot_map[c][a][s]) begin
            slot_map[c][a][s] = 1'b1;
            if (s == NSLOT - 1) slot_map[c][a][0] = 1'b1;
            res.arena = 2'(a);
            res.slot = 9'(s);
            found = 1;
            break;
          end
        end
      end
      if (found) begin
        res.cls = 5'(c);
        res.bsize = 21'd1 << (c + MIN_SHIFT);
      end else begin
        res.status = ST_OOM;
      end
    end else begin
      if (r.slot == 0 || r.arena >= NARENA) begin
        res.status = ST_BAD;
      end else begin
        slot_map[c][r.arena][0] = 1'b0;
        slot_map[c][r.arena][r.slot] = 1'b0;
        res.cls = 5'(c);
        res.arena = r.arena;
        res.slot = r.slot;
        res.bsize = 21'd1 << (c + MIN_SHIFT);
      end
    end
    if (res.status != ST_OK) begin
      res.cls = '0;
      res.arena = '0;
      res.slot = '0;
      res.bsize = '0;
    end
    return res;
  endfunction

  function automatic alloc_req_t make_req(input logic op, input logic [23:0] sz,
                                          input logic [1:0] ar, input logic [8:0] sl);
    alloc_req_t r;
    r.op = op;
    r.size = sz;
    r.arena = ar;
    r.slot = sl;
    return r;
  endfunction

  // Mostly small, in-range sizes; now and then extreme or random 24-bit ones.
  function automatic logic [23:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 24'($urandom_range(1, 256));
    if (sel < 80) return 24'd1 << $urandom_range(0, 20);
    if (sel < 88) return 24'($urandom_range(1, 1 << 20));
    if (sel < 94) return 24'($urandom);
    if (sel < 97) return 24'd0;
    return (24'd1 << 20) + 24'd1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fill the request queue: a directed opening, then random traffic that is
  // mostly allocate, with frees in the class of an earlier one and noise frees.
  initial begin
    alloc_req_t r;
    int idx;
    foreach (slot_map[c, a]) slot_map[c][a] = '0;
    pending_reqs.push_back(make_req(OP_ALLOC, 24'd0, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_FREE, 24'd0, 2'd3, 9'd511));
    pending_reqs.push_back(make_req(OP_ALLOC, 24'd1, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_ALLOC, 24'd16, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_ALLOC, 24'd17, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_ALLOC, 24'd1 << 20, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_ALLOC, (24'd1 << 20) + 24'd1, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_ALLOC, 24'hFFFFFF, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_FREE, 24'hFFFFFF, 2'd1, 9'd1));
    pending_reqs.push_back(make_req(OP_FREE, 24'd16, 2'd0, 9'd1));
    // A double free of the same handle still reports ok.
    pending_reqs.push_back(make_req(OP_FREE, 24'd16, 2'd0, 9'd1));
    // Slot 0 is a bad handle; slot 511 is the last valid one.
    pending_reqs.push_back(make_req(OP_FREE, 24'd16, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_FREE, 24'd32, 2'd3, 9'd511));
    pending_reqs.push_back(make_req(OP_FREE, 24'd1 << 20, 2'd2, 9'd256));
    // Fill the first arena of the 64-byte class so the next allocation moves
    // on to the second arena; then free its last slot and take it again.
    for (int i = 0; i < NSLOT - 1; i++)
      pending_reqs.push_back(make_req(OP_ALLOC, 24'd64, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_ALLOC, 24'd50, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_FREE, 24'd64, 2'd0, 9'd511));
    pending_reqs.push_back(make_req(OP_ALLOC, 24'd64, 2'd0, 9'd0));
    pending_reqs.push_back(make_req(OP_ALLOC, 24'd64, 2'd0, 9'd0));
    for (int i = 0; i < 420; i++) begin
      if ($urandom_range(0, 99) < 55 || live_blocks.size() == 0) begin
        r = make_req(OP_ALLOC, pick_size(), 2'($urandom), 9'($urandom));
        if (r.size != 0 && size_to_class(r.size) >= 0)
          live_blocks.push_back(r);
      end else if ($urandom_range(0, 99) < 80) begin
        idx = int'($urandom_range(0, live_blocks.size() - 1));
        r = live_blocks[idx];
        live_blocks.delete(idx);
        // The arena and slot guessed here are random; the handle is still
        // meaningful because the class comes from the original size.
        r.op = OP_FREE;
        r.arena = 2'($urandom_range(0, 1));
        r.slot = 9'($urandom_range(1, 8));
      end else begin
        r = make_req(OP_FREE, pick_size(), 2'($urandom), 9'($urandom));
      end
      pending_reqs.push_back(r);
    end
  end

  // Phase control for idling, plus the long receiver hold-off.
  initial begin
    rst_n = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 70;
    hold_off_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Hold the receiver off while the sender keeps pushing, so the queue fills.
    wait (pending_reqs.size() < 900);
    @(posedge clk);
    hold_off_cycles <= 300;
    repeat (300) @(posedge clk);
    hold_off_cycles <= 0;
    wait (pending_reqs.size() < 600);
    @(posedge clk);
    send_idle_pct = 70;
    recv_idle_pct = 14;
    wait (pending_reqs.size() < 300);
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
  end

  // Driver: present the head request, retire it once accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_opcode <= 1'b0;
      in_request_size <= '0;
      in_free_arena <= '0;
      in_free_slot <= '0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(predict_allocation(pending_reqs.pop_front()));
      end
      if ((push && !full) || !push) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          push <= 1'b1;
          in_opcode <= pending_reqs[0].op;
          in_request_size <= pending_reqs[0].size;
          in_free_arena <= pending_reqs[0].arena;
          in_free_slot <= pending_reqs[0].slot;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: pop results and compare each with the oldest expectation.
  always @(posedge clk) begin
    scba_res_t exp_res;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result status=%0d", out_status);
        end else begin
          exp_res = expected_results.pop_front();
          if (out_status !== exp_res.status || out_class_index !== exp_res.cls ||
              out_arena_index !== exp_res.arena || out_slot_index !== exp_res.slot ||
              out_block_size !== exp_res.bsize) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result error exp st=%0d c=%0d a=%0d s=%0d b=%0d",
                        " got st=%0d c=%0d a=%0d s=%0d b=%0d"},
                       exp_res.status, exp_res.cls, exp_res.arena, exp_res.slot,
                       exp_res.bsize, out_status, out_class_index, out_arena_index,
                       out_slot_index, out_block_size);
          end
        end
      end
      if (hold_off_cycles > 0) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: counts cycles in which no request or result moves.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) wdog <= 0;
    else wdog <= wdog + 1;
  end

  initial begin
    mismatch_count = 0;
    wdog = 0;
    stim_done = 0;
    wait (rst_n === 1'b1);
    fork
      begin
        wait (pending_reqs.size() == 0 && !push);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge clk);
        stim_done = 1;
      end
      begin
        wait (wdog >= WDOG_MAX);
      end
    join_any
    if (stim_done && mismatch_count == 0) begin
      $display("size_class_bitmap_allocator_top: match");
    end else begin
      $display("size_class_bitmap_allocator_top: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/scba_pkg.sv
hdl/scba_front.sv
hdl/scba_back.sv
hdl/size_class_bitmap_allocator_top.sv
sim/tb_size_class_bitmap_allocator_top.sv
